// File: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and constants of the max priority queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int IN_VALUE_W = 32;
    localparam int OCC_W      = 7;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [IN_VALUE_W-1:0] value;
    } bmhq_req_t;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] popped_value;
        logic                  popped_valid;
        logic                  underflow;
        logic                  overflow;
        logic [OCC_W-1:0]      occupancy;
    } bmhq_rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } bmhq_ctl_t;

endpackage

// File: rtl/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq channel interfaces
// valid/ready channels for the request and response beats
// ----------------------------------------------------------------------------
interface bmhq_req_if
    import bmhq_pkg::*;
();
    logic      valid;
    logic      ready;
    bmhq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bmhq_rsp_if
    import bmhq_pkg::*;
();
    logic      valid;
    logic      ready;
    bmhq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bmhq_cell.sv
// ----------------------------------------------------------------------------
// bmhq_cell
// one slot of the sorted chain; holds one value, shifts right on insert
// and left on removal
// ----------------------------------------------------------------------------
module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  bmhq_ctl_t             ctl,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  occupied,
    input  logic                  prev_keep,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic [VALUE_BITS-1:0] next_value,
    output logic                  keep,
    output logic [VALUE_BITS-1:0] slot_value
);

    logic [VALUE_BITS-1:0] slot_reg;
    logic [VALUE_BITS-1:0] slot_next;

    // chain is sorted descending, so keep is high on a prefix of cells
    assign keep = occupied && (slot_reg >= value);

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.push_en)
        begin
            if (keep)
                slot_next = slot_reg;
            else if (prev_keep)
                slot_next = value;
            else
                slot_next = prev_value;
        end
        else if (ctl.pop_en)
        begin
            slot_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_value = slot_reg;

endmodule

// File: rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// max priority queue built as a sorted chain of value cells
// ----------------------------------------------------------------------------
// req carries one beat per operation: action selects push or pop, value is
// the element to insert. rsp returns one beat per request with the removed
// maximum, underflow / overflow flags and the occupancy after the operation.
// the cells keep their values sorted largest first; a push inserts the value
// in place while smaller ones move one cell down, a pop moves every cell one
// place up, every cell updating in the same cycle.
// the response beat is registered and appears in the cycle after the request beat.
// throughput: one beat per cycle while rsp.ready is high, set by the single compare per cell.
// req.ready is high while the response register is empty or being drained,
// so a stalled receiver holds the response and stops new requests after one.
// reset clears the occupancy count and the response valid flag; cell contents
// are not cleared and are read only below the count.
// a push into a full queue is dropped with overflow; a pop from an empty
// queue returns zero with underflow.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    bmhq_rsp_t        rsp_data_reg;
    bmhq_rsp_t        rsp_data_next;

    logic                  accept;
    logic                  is_pop;
    logic                  full;
    logic                  empty;
    bmhq_ctl_t             ctl;
    logic [VALUE_BITS-1:0] in_value;

    logic [VALUE_BITS-1:0] slot_value [CAPACITY];
    logic                  keep       [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_pop    = (req.data.action == ACT_POP);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign in_value  = VALUE_BITS'(req.data.value);

    assign ctl.push_en = accept && !is_pop && !full;
    assign ctl.pop_en  = accept && is_pop && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  occupied;
            logic                  prev_keep;
            logic [VALUE_BITS-1:0] prev_value;
            logic [VALUE_BITS-1:0] next_value;

            assign occupied = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_keep  = 1'b1;
                assign prev_value = '0;
            end
            else
            begin : g_body
                assign prev_keep  = keep[i-1];
                assign prev_value = slot_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_value = '0;
            end
            else
            begin : g_link
                assign next_value = slot_value[i+1];
            end

            bmhq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .value      (in_value),
                .occupied   (occupied),
                .prev_keep  (prev_keep),
                .prev_value (prev_value),
                .next_value (next_value),
                .keep       (keep[i]),
                .slot_value (slot_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push_en)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.pop_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp.ready)
            rsp_valid_next = 1'b0;
        if (accept)
        begin
            rsp_valid_next             = 1'b1;
            rsp_data_next.popped_value = ctl.pop_en ? IN_VALUE_W'(slot_value[0]) : '0;
            rsp_data_next.popped_valid = ctl.pop_en;
            rsp_data_next.underflow    = is_pop && empty;
            rsp_data_next.overflow     = !is_pop && full;
            rsp_data_next.occupancy    = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule
